>>> rtl/cos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cos_pkg: shared types and constants for the count order sorter
// Field widths, register reset value and the control bundle of the cells.
// ----------------------------------------------------------------------------
package cos_pkg;

    // Width of one letter count, unsigned Q1.15
    localparam int CNT_W = 16;
    // Width of a letter index
    localparam int IDX_W = 5;
    // Width of the alphabet size register
    localparam int CFG_W = 5;
    // Width of an effective size or a drain counter (values up to 31)
    localparam int SIZE_W = 6;

    // Alphabet size after reset
    localparam logic [CFG_W-1:0] RESET_SIZE = 5'd20;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place a new count in rank order
        logic drain;    // shift the chain one place towards cell 0
    } t_cell_ctl;

endpackage

>>> rtl/cos_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cos_cell: one rank of the sorting chain
// Holds one count and its letter index. On insert it keeps its entry, takes
// the new one or takes its left neighbour's; on drain it takes its right
// neighbour's entry.
// ----------------------------------------------------------------------------
module cos_cell (
    input  logic                     i_clk,
    input  cos_pkg::t_cell_ctl       i_ctl,
    input  logic                     i_occupied,
    input  logic [cos_pkg::CNT_W-1:0] i_new_count,
    input  logic [cos_pkg::IDX_W-1:0] i_new_index,
    input  logic                     i_left_pass,
    input  logic [cos_pkg::CNT_W-1:0] i_left_count,
    input  logic [cos_pkg::IDX_W-1:0] i_left_index,
    input  logic [cos_pkg::CNT_W-1:0] i_right_count,
    input  logic [cos_pkg::IDX_W-1:0] i_right_index,
    output logic                     o_pass,
    output logic [cos_pkg::CNT_W-1:0] o_count,
    output logic [cos_pkg::IDX_W-1:0] o_index
);
    import cos_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_index;
    logic [CNT_W-1:0] n_count;
    logic [IDX_W-1:0] n_index;

    // Pass when this rank is empty or the new count ranks above its entry
    assign o_pass = !(i_occupied && (r_count >= i_new_count));

    // Select the next entry of this rank
    always_comb begin
        n_count = r_count;
        n_index = r_index;
        if (i_ctl.insert && o_pass) begin
            if (i_left_pass) begin
                n_count = i_left_count;
                n_index = i_left_index;
            end else begin
                n_count = i_new_count;
                n_index = i_new_index;
            end
        end else if (i_ctl.drain) begin
            n_count = i_right_count;
            n_index = i_right_index;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        r_index <= n_index;
    end

    assign o_count = r_count;
    assign o_index = r_index;

endmodule

>>> rtl/count_order_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// count_order_sort: stable descending ordering of letter counts
// Collects one count per letter and emits the letter indices by rank.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a count (unsigned Q1.15) is taken at a clock edge with
//   start high and busy low. Counts arrive in letter order, letter 0 first.
//   Each count is placed in rank order in the cell chain in the cycle it is
//   taken, so one count a cycle is accepted while collecting.
//   Once the count of the last letter is in, busy rises in the next cycle
//   and the chain shifts towards cell 0 once a cycle: one letter index per
//   cycle on o_letter_index with o_strobe, highest count first, equal counts
//   in ascending letter order, o_last_rank on the final one. busy falls in
//   the cycle after that final result. A full sort of N letters collects N
//   counts and then drains N results; no count is taken while it drains.
//   Results cannot be stalled: each is valid for exactly one cycle.
//   Configuration: a write on the cfg channel sets the alphabet size (zero
//   acts as 1, above MAX_LETTERS as MAX_LETTERS) and discards any counts
//   collected so far. Write only while idle.
//   Reset: alphabet size 20, collection empty, no results pending.
// ----------------------------------------------------------------------------
module count_order_sort #(
    parameter int MAX_LETTERS = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [cos_pkg::CNT_W-1:0]   i_letter_count,
    output logic                        o_strobe,
    output logic [cos_pkg::IDX_W-1:0]   o_letter_index,
    output logic                        o_last_rank,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cos_pkg::CFG_W-1:0]   i_cfg_data
);
    import cos_pkg::*;

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_LETTERS);

    logic [CFG_W-1:0]  r_size;
    logic [CFG_W-1:0]  n_size;
    logic [IDX_W-1:0]  r_have;
    logic [IDX_W-1:0]  n_have;
    logic              r_draining;
    logic              n_draining;
    logic [SIZE_W-1:0] r_left;
    logic [SIZE_W-1:0] n_left;

    logic [SIZE_W-1:0] eff_size;
    logic [SIZE_W-1:0] have;
    logic [SIZE_W-1:0] have_next;
    logic              accept;
    logic              cfg_write;
    t_cell_ctl         ctl;

    logic [CNT_W-1:0]  cell_count [MAX_LETTERS];
    logic [IDX_W-1:0]  cell_index [MAX_LETTERS];
    logic              cell_pass  [MAX_LETTERS];

    // Clamp the configured size to 1..MAX_LETTERS
    always_comb begin
        eff_size = {1'b0, r_size};
        if (r_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (eff_size > MAX_SIZE) begin
            eff_size = MAX_SIZE;
        end
    end

    // Handshakes
    assign busy        = r_draining;
    assign accept      = start && !r_draining;
    assign o_cfg_ready = !r_draining;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // Counts held in this collection; restart if it is already full
    assign have      = ({1'b0, r_have} >= eff_size) ? '0 : {1'b0, r_have};
    assign have_next = have + SIZE_W'(1);

    assign ctl.insert = accept;
    assign ctl.drain  = r_draining;

    // Next state of collection and drain control
    always_comb begin
        n_size     = r_size;
        n_have     = r_have;
        n_draining = r_draining;
        n_left     = r_left;
        if (cfg_write) begin
            n_size = i_cfg_data;
            n_have = '0;
        end else if (accept) begin
            if (have_next == eff_size) begin
                n_have     = '0;
                n_draining = 1'b1;
                n_left     = eff_size;
            end else begin
                n_have = have_next[IDX_W-1:0];
            end
        end
        if (r_draining) begin
            n_left = r_left - SIZE_W'(1);
            if (r_left == SIZE_W'(1)) begin
                n_draining = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= RESET_SIZE;
            r_have     <= '0;
            r_draining <= 1'b0;
            r_left     <= '0;
        end else begin
            r_size     <= n_size;
            r_have     <= n_have;
            r_draining <= n_draining;
            r_left     <= n_left;
        end
    end

    // Chain of rank cells, cell 0 holds the highest count
    for (genvar k = 0; k < MAX_LETTERS; k++) begin : g_cell
        logic             left_pass;
        logic [CNT_W-1:0] left_count;
        logic [IDX_W-1:0] left_index;
        logic [CNT_W-1:0] right_count;
        logic [IDX_W-1:0] right_index;

        if (k == 0) begin : g_head
            assign left_pass  = 1'b0;
            assign left_count = '0;
            assign left_index = '0;
        end else begin : g_body
            assign left_pass  = cell_pass[k-1];
            assign left_count = cell_count[k-1];
            assign left_index = cell_index[k-1];
        end

        if (k == MAX_LETTERS - 1) begin : g_tail
            assign right_count = '0;
            assign right_index = '0;
        end else begin : g_inner
            assign right_count = cell_count[k+1];
            assign right_index = cell_index[k+1];
        end

        cos_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_occupied    (SIZE_W'(k) < have),
            .i_new_count   (i_letter_count),
            .i_new_index   (have[IDX_W-1:0]),
            .i_left_pass   (left_pass),
            .i_left_count  (left_count),
            .i_left_index  (left_index),
            .i_right_count (right_count),
            .i_right_index (right_index),
            .o_pass        (cell_pass[k]),
            .o_count       (cell_count[k]),
            .o_index       (cell_index[k])
        );
    end

    // Emit the head of the chain while draining
    assign o_strobe       = r_draining;
    assign o_letter_index = cell_index[0];
    assign o_last_rank    = r_draining && (r_left == SIZE_W'(1));

endmodule

>>> rtl/cos_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cos_checker: port-level checks for the count order sorter
// Watches results and busy over time; bound to the top level.
// ----------------------------------------------------------------------------
module cos_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input logic o_last_rank
);
    // Results only appear while busy
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe without busy");

    // The final flag only marks a real result
    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_rank |-> o_strobe)
        else $error("last rank flag without result");

    // Drain ends with the final result
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_rank |=> !busy && !o_strobe)
        else $error("results continue after last rank");

    // Busy only rises after an accepted count
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transaction");

    // Reset leaves no result pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("result pending after reset");

endmodule

bind count_order_sort cos_checker u_cos_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_last_rank (o_last_rank)
);

>>> tb/count_order_sort_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// count_order_sort_tb: self-checking bench for the count order sorter
// Feeds letter counts over the command channel, rewrites the alphabet size
// between phases and checks every ranked letter index against a
// stable descending insertion sort kept in a scoreboard class.
// ----------------------------------------------------------------------------
module count_order_sort_tb;

    import cos_pkg::*;

    localparam int MAX_LETTERS   = 20;
    // Cycles to let pass once idle before touching the size register
    localparam int SETTLE_CYCLES = MAX_LETTERS + 4;
    localparam int RANDOM_ITEMS  = 335;

    // One expected rank: letter index and final-rank flag
    typedef struct packed {
        logic [IDX_W-1:0] letter;
        logic             is_last;
    } t_rank;

    // ------------------------------------------------------------------------
    // Scoreboard: stable descending insertion of counts, queue of ranks
    // ------------------------------------------------------------------------
    class letter_rank_board;
        logic [CFG_W-1:0] alphabet;
        logic [CNT_W-1:0] rank_count [MAX_LETTERS];
        logic [IDX_W-1:0] rank_letter [MAX_LETTERS];
        int unsigned      collected;
        t_rank            expected_ranks [$];
        int unsigned      mismatch_count;

        function new();
            alphabet       = RESET_SIZE;
            collected      = 0;
            mismatch_count = 0;
        endfunction

        // A size write drops any partial collection
        function void set_alphabet(logic [CFG_W-1:0] size);
            alphabet  = size;
            collected = 0;
        endfunction

        function int unsigned letters_per_sort();
            int unsigned n;
            n = alphabet;
            if (n == 0) n = 1;
            if (n > MAX_LETTERS) n = MAX_LETTERS;
            return n;
        endfunction

        function int unsigned ranks_pending();
            return expected_ranks.size();
        endfunction

        // Place one count after every stored count that is not smaller
        function void note_count(logic [CNT_W-1:0] cnt);
            int unsigned size;
            int unsigned have;
            int unsigned pos;
            t_rank       r;
            size = letters_per_sort();
            have = (collected >= size) ? 0 : collected;
            pos  = 0;
            while (pos < have && rank_count[pos] >= cnt) pos++;
            for (int unsigned k = have; k > pos; k--) begin
                rank_count[k]  = rank_count[k-1];
                rank_letter[k] = rank_letter[k-1];
            end
            rank_count[pos]  = cnt;
            rank_letter[pos] = IDX_W'(have);
            have++;
            if (have < size) begin
                collected = have;
            end else begin
                // Alphabet complete: queue the whole ordering
                for (int unsigned k = 0; k < have; k++) begin
                    r.letter  = rank_letter[k];
                    r.is_last = (k + 1 == have);
                    expected_ranks.push_back(r);
                end
                collected = 0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_rank(logic [IDX_W-1:0] letter, logic is_last);
            t_rank want;
            if (expected_ranks.size() == 0) begin
                report_mismatch($sformatf("unexpected result, index %0d last %0b",
                                          letter, is_last));
                return;
            end
            want = expected_ranks.pop_front();
            if (letter !== want.letter)
                report_mismatch($sformatf("letter_index %0d, expected %0d",
                                          letter, want.letter));
            if (is_last !== want.is_last)
                report_mismatch($sformatf("last_rank %0b, expected %0b",
                                          is_last, want.is_last));
        endtask

        task close_out();
            if (expected_ranks.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          expected_ranks.size()));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [CNT_W-1:0] i_letter_count;
    logic o_strobe;
    logic [IDX_W-1:0] o_letter_index;
    logic o_last_rank;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    letter_rank_board board;

    // Opening collection at the reset size: extremes, ties, values above 1.0
    logic [CNT_W-1:0] opening_counts [20] = '{
        16'd0,     16'd32768, 16'd65535, 16'd1,     16'd32768,
        16'd0,     16'd16384, 16'd65535, 16'd32767, 16'd16384,
        16'h8001,  16'h5555,  16'hAAAA,  16'd100,   16'd100,
        16'd100,   16'd0,     16'd32768, 16'd2,     16'd65534
    };

    count_order_sort #(
        .MAX_LETTERS    (MAX_LETTERS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_letter_count (i_letter_count),
        .o_strobe       (o_strobe),
        .o_letter_index (o_letter_index),
        .o_last_rank    (o_last_rank),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Observe every transaction at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) board.set_alphabet(i_cfg_data);
            if (o_strobe) board.check_rank(o_letter_index, o_last_rank);
            if (start && !busy) board.note_count(i_letter_count);
        end
    end

    // Offer one count, hold until taken, then idle for the given gap
    task send_count(input logic [CNT_W-1:0] cnt, input int unsigned gap);
        start          <= 1'b1;
        i_letter_count <= cnt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every queued rank has come out
    task hold_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.ranks_pending() != 0 || busy) @(posedge i_clk);
    endtask

    // Write the alphabet size once the block is idle
    task write_alphabet(input logic [CFG_W-1:0] size);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'd32768;
            2:       return CNT_W'($urandom_range(0, 65535));
            3, 4:    return CNT_W'($urandom_range(0, 4) * 8192);
            default: return CNT_W'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_alphabet(int unsigned phase);
        case (phase)
            0:       return 5'd31;
            1:       return 5'd1;
            2:       return 5'd20;
            default: begin
                case ($urandom_range(0, 7))
                    0:       return 5'd0;
                    1:       return 5'd2;
                    2:       return 5'd4;
                    3:       return CFG_W'($urandom_range(21, 31));
                    default: return CFG_W'($urandom_range(1, 20));
                endcase
            end
        endcase
    endfunction

    // Stimulus and final verdict
    initial begin
        int unsigned      sent;
        int unsigned      phase;
        int unsigned      letters;
        int unsigned      phase_items;
        logic [CFG_W-1:0] size;
        bit               steady;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_letter_count = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        board          = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full collection at the reset size
        foreach (opening_counts[i]) send_count(opening_counts[i], i % 3);
        hold_until_drained();

        // Partial collection discarded by a size write, then size zero
        write_alphabet(5'd3);
        send_count(16'd500, 0);
        send_count(16'd65535, 1);
        write_alphabet(5'd0);
        send_count(16'd12345, 0);
        // Two equal counts keep letter order
        write_alphabet(5'd2);
        send_count(16'd7000, 0);
        send_count(16'd7000, 2);

        // Random phases, each with its own size and idling mode
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            size = pick_alphabet(phase);
            write_alphabet(size);
            letters = (size == 0) ? 1 : ((size > MAX_LETTERS) ? MAX_LETTERS : size);
            phase_items = letters * $urandom_range(1, 3);
            if (letters > 1 && $urandom_range(0, 2) == 0)
                phase_items += $urandom_range(1, letters - 1);
            steady = ($urandom_range(0, 3) == 0);
            for (int unsigned i = 0; i < phase_items && sent < RANDOM_ITEMS; i++) begin
                if ($urandom_range(0, 31) == 0) hold_until_drained();
                send_count(pick_count(), steady ? 0 : $urandom_range(0, 8));
                sent++;
            end
            phase++;
        end

        // Drain and settle
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        board.close_out();
        if (board.mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> count_order_sort.f
rtl/cos_pkg.sv
rtl/cos_cell.sv
rtl/count_order_sort.sv
rtl/cos_checker.sv
tb/count_order_sort_tb.sv
